// ===== rtl/i2b_pkg.sv =====
`default_nettype none
package i2b_pkg;

  localparam int MaxDigits = 64;
  localparam int MaxRadix  = 16;
  // at most MaxDigits - 1 digits are kept, never more than 63
  localparam int DigitLimit = (MaxDigits - 1 > 63) ? 63 : MaxDigits - 1;
  localparam int AddrW      = $clog2(MaxDigits);
  localparam int CountW     = $clog2(MaxDigits + 1);

  localparam logic [7:0] SignChar = 8'h2d;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegBaseSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCharsLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCharsHigh = 2'd2;

  localparam logic [4:0]  BaseSizeReset  = 5'd10;
  localparam logic [63:0] CharsLowReset  = 64'd3978425819141910832;
  localparam logic [63:0] CharsHighReset = 64'd7378413942531504440;

  // datapath operations
  localparam logic [2:0] OpNop   = 3'd0;
  localparam logic [2:0] OpLoad  = 3'd1;
  localparam logic [2:0] OpDiv   = 3'd2;
  localparam logic [2:0] OpStore = 3'd3;
  localparam logic [2:0] OpSign  = 3'd4;
  localparam logic [2:0] OpRead  = 3'd5;
  localparam logic [2:0] OpEmit  = 3'd6;

  // wait conditions
  localparam logic [1:0] WaitNone = 2'd0;
  localparam logic [1:0] WaitIn   = 2'd1;
  localparam logic [1:0] WaitOut  = 2'd2;

  // branch conditions
  localparam logic [2:0] BrNever      = 3'd0;
  localparam logic [2:0] BrAlways     = 3'd1;
  localparam logic [2:0] BrDivBusy    = 3'd2;
  localparam logic [2:0] BrMoreDigits = 3'd3;
  localparam logic [2:0] BrMoreEmit   = 3'd4;

  // program steps
  localparam int StepW = 3;
  localparam logic [StepW-1:0] StepIdle  = 3'd0;
  localparam logic [StepW-1:0] StepDiv   = 3'd1;
  localparam logic [StepW-1:0] StepStore = 3'd2;
  localparam logic [StepW-1:0] StepSign  = 3'd3;
  localparam logic [StepW-1:0] StepRead  = 3'd4;
  localparam logic [StepW-1:0] StepEmit  = 3'd5;
  localparam logic [StepW-1:0] StepDone  = 3'd6;

  typedef struct packed {
    logic [2:0]       op;
    logic [1:0]       wait_sel;
    logic [2:0]       br_sel;
    logic [StepW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic [2:0] op;
    logic       fire;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic div_busy;
    logic more_digits;
    logic more_emit;
  } status_t;

  function automatic logic [7:0] digit_char(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] d);
    logic [63:0] w;
    w = d[3] ? hi : lo;
    w = w >> {d[2:0], 3'b000};
    return w[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/i2b_ucode_rom.sv =====
`default_nettype none
module i2b_ucode_rom
  import i2b_pkg::*;
(
  input  wire logic [StepW-1:0] step_i,
  output ucode_t                word_o
);

  always_comb begin
    case (step_i)
      StepIdle:  word_o = '{op: OpLoad,  wait_sel: WaitIn,   br_sel: BrNever,      target: StepIdle};
      StepDiv:   word_o = '{op: OpDiv,   wait_sel: WaitNone, br_sel: BrDivBusy,    target: StepDiv};
      StepStore: word_o = '{op: OpStore, wait_sel: WaitNone, br_sel: BrMoreDigits, target: StepDiv};
      StepSign:  word_o = '{op: OpSign,  wait_sel: WaitOut,  br_sel: BrNever,      target: StepIdle};
      StepRead:  word_o = '{op: OpRead,  wait_sel: WaitNone, br_sel: BrNever,      target: StepIdle};
      StepEmit:  word_o = '{op: OpEmit,  wait_sel: WaitOut,  br_sel: BrMoreEmit,   target: StepRead};
      StepDone:  word_o = '{op: OpNop,   wait_sel: WaitNone, br_sel: BrAlways,     target: StepIdle};
      default:   word_o = '{op: OpNop,   wait_sel: WaitNone, br_sel: BrAlways,     target: StepIdle};
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/i2b_sequencer.sv =====
`default_nettype none
module i2b_sequencer
  import i2b_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ucode_t           word_i,
  input  wire status_t          status_i,
  output logic [StepW-1:0]      step_o,
  output ctrl_t                 ctrl_o,
  output logic                  idle_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             fire;
  logic             take;

  always_comb begin
    case (word_i.wait_sel)
      WaitNone: fire = 1'b1;
      WaitIn:   fire = status_i.in_valid;
      WaitOut:  fire = status_i.out_free;
      default:  fire = 1'b1;
    endcase
  end

  always_comb begin
    case (word_i.br_sel)
      BrNever:      take = 1'b0;
      BrAlways:     take = 1'b1;
      BrDivBusy:    take = status_i.div_busy;
      BrMoreDigits: take = status_i.more_digits;
      BrMoreEmit:   take = status_i.more_emit;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    if (!fire) begin
      step_d = step_q;
    end else if (take) begin
      step_d = word_i.target;
    end else begin
      step_d = step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign step_o      = step_q;
  assign ctrl_o.op   = word_i.op;
  assign ctrl_o.fire = fire;
  assign idle_o      = (step_q == StepIdle);

endmodule
`default_nettype wire

// ===== rtl/i2b_digit_ram.sv =====
`default_nettype none
module i2b_digit_ram
  import i2b_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [3:0]       wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic [3:0]            rd_data_o
);

  logic [3:0] mem [MaxDigits];
  logic [3:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/i2b_datapath.sv =====
`default_nettype none
module i2b_datapath
  import i2b_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_t              ctrl_i,
  output status_t                 status_o,
  input  wire logic               in_valid_i,
  input  wire logic signed [63:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              character_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  output logic                    wr_en_o,
  output logic [AddrW-1:0]        wr_addr_o,
  output logic [3:0]              wr_data_o,
  output logic                    rd_en_o,
  output logic [AddrW-1:0]        rd_addr_o,
  input  wire logic [3:0]         rd_data_i
);

  // eight restoring division steps on one byte of the dividend
  function automatic logic [11:0] div_byte(input logic [7:0] bits, input logic [3:0] rem,
                                          input logic [4:0] radix);
    logic [4:0] r;
    logic [4:0] t;
    logic [7:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r[3:0], bits[i]};
      if (t >= radix) begin
        q[i] = 1'b1;
        r    = t - radix;
      end else begin
        r    = t;
      end
    end
    return {q, r[3:0]};
  endfunction

  logic [4:0]        base_q;
  logic [63:0]       lo_q;
  logic [63:0]       hi_q;
  logic [63:0]       mag_q, mag_d;
  logic [3:0]        rem_q, rem_d;
  logic [2:0]        chunk_q, chunk_d;
  logic [CountW-1:0] count_q, count_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;

  logic [4:0]        radix;
  logic [63:0]       v_sat;
  logic [11:0]       div_res;
  logic [CountW-1:0] count_inc;
  logic              out_free;
  logic              act;

  always_comb begin
    if (base_q < 5'd2) begin
      radix = 5'd2;
    end else if (base_q > 5'(MaxRadix)) begin
      radix = 5'(MaxRadix);
    end else begin
      radix = base_q;
    end
  end

  // most negative value saturates one step up
  assign v_sat = (value_i == {1'b1, 63'd0}) ? {1'b1, 62'd0, 1'b1} : value_i;

  assign div_res   = div_byte(mag_q[63:56], rem_q, radix);
  assign count_inc = count_q + CountW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign status_o.in_valid    = in_valid_i;
  assign status_o.out_free    = out_free;
  assign status_o.div_busy    = (chunk_q != 3'd7);
  assign status_o.more_digits = (mag_q != 64'd0) && (count_inc < CountW'(DigitLimit));
  assign status_o.more_emit   = (count_q != CountW'(1));

  assign act = ctrl_i.fire;

  always_comb begin
    mag_d       = mag_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    count_d     = count_q;
    neg_d       = neg_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en_o     = 1'b0;
    rd_en_o     = 1'b0;
    if (act) begin
      case (ctrl_i.op)
        OpLoad: begin
          neg_d   = v_sat[63];
          mag_d   = v_sat[63] ? (~v_sat + 64'd1) : v_sat;
          rem_d   = '0;
          chunk_d = '0;
          count_d = '0;
        end
        OpDiv: begin
          // quotient bits shift in behind the dividend
          mag_d   = {mag_q[55:0], div_res[11:4]};
          rem_d   = div_res[3:0];
          chunk_d = chunk_q + 3'd1;
        end
        OpStore: begin
          wr_en_o = 1'b1;
          count_d = count_inc;
          rem_d   = '0;
        end
        OpSign: begin
          if (neg_q) begin
            out_valid_d = 1'b1;
            char_d      = SignChar;
            last_d      = 1'b0;
          end
        end
        OpRead: begin
          rd_en_o = 1'b1;
        end
        OpEmit: begin
          out_valid_d = 1'b1;
          char_d      = digit_char(lo_q, hi_q, rd_data_i);
          last_d      = (count_q == CountW'(1));
          count_d     = count_q - CountW'(1);
        end
        OpNop: begin
          mag_d = '0;
        end
        default: begin
          mag_d = mag_q;
        end
      endcase
    end
  end

  assign wr_addr_o = count_q[AddrW-1:0];
  assign wr_data_o = rem_q;
  assign rd_addr_o = AddrW'(count_q - CountW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BaseSizeReset;
      lo_q        <= CharsLowReset;
      hi_q        <= CharsHighReset;
      mag_q       <= '0;
      rem_q       <= '0;
      chunk_q     <= '0;
      count_q     <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegBaseSize:  base_q <= cfg_data_i[4:0];
          RegCharsLow:  lo_q   <= cfg_data_i;
          RegCharsHigh: hi_q   <= cfg_data_i;
          default:      base_q <= base_q;
        endcase
      end
      mag_q       <= mag_d;
      rem_q       <= rem_d;
      chunk_q     <= chunk_d;
      count_q     <= count_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// ===== rtl/integer_to_base_digits_core.sv =====
`default_nettype none
// integer to text in a configurable radix (2 to 16)
//
// input channel: value_i with in_valid_i / in_stall_o; a word is taken while the
// core is idle. output channel: character_o and last_o with out_valid_o /
// out_stall_i, one character per word, most significant first, a leading '-'
// for negative values, last_o high on the final digit.
// configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 base size,
// 1 digit characters 0 to 7, 2 digit characters 8 to 15) and cfg_data_i;
// writes are expected only while the core is idle.
// timing: a microcoded sequencer drives one shared divider that retires one
// byte of the 64-bit magnitude per cycle, so each digit costs a divide step per
// byte and a store step. an item then runs a sign step, a read and an emit
// step per digit and a done step before the next word is taken, and any
// stall from the receiver holds it.
// reset clears the sequencer and output valid and restores the default base
// and characters. a stalled output holds its character and the sequencer waits
// on the emit step until it is taken.
module integer_to_base_digits_core
  import i2b_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [63:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              character_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);

  logic [StepW-1:0] step;
  ucode_t           word;
  ctrl_t            ctrl;
  status_t          status;
  logic             idle;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [3:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [3:0]       rd_data;

  i2b_ucode_rom u_rom (
    .step_i (step),
    .word_o (word)
  );

  i2b_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (word),
    .status_i (status),
    .step_o   (step),
    .ctrl_o   (ctrl),
    .idle_o   (idle)
  );

  i2b_digit_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  i2b_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  assign in_stall_o  = !idle;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire
